### hw/rtl/window_median_filter_defines.svh
// ----------------------------------------------------------------------------
// window median filter assertion macros
// concurrent check helpers for the rtl file that asserts
// ----------------------------------------------------------------------------
`ifndef WINDOW_MEDIAN_FILTER_DEFINES_SVH
`define WINDOW_MEDIAN_FILTER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define WMF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define WMF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/wmf_pkg.sv
// ----------------------------------------------------------------------------
// wmf_pkg
// shared types, codes and constants of the window median filter
// ----------------------------------------------------------------------------
package wmf_pkg;

    localparam int PIX_W  = 8;
    localparam int CFG_W  = 11;
    localparam int RAD_W  = 2;
    localparam int IDX_W  = 2;

    // register indexes
    localparam logic [IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] CFG_RADIUS       = 2'd2;

    localparam logic [CFG_W-1:0] RST_WIDTH  = 11'd640;
    localparam logic [CFG_W-1:0] RST_HEIGHT = 11'd480;
    localparam logic [RAD_W-1:0] RST_RADIUS = 2'd3;

    // input word opcodes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POS,
        ST_DEC,
        ST_READ,
        ST_WAIT,
        ST_SEL,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic take;
        logic pos;
        logic dec;
        logic rd_issue;
        logic sel_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic emit;
        logic rd_last;
        logic sel_last;
        logic out_free;
        logic last;
        logic frame_done;
    } t_status;

    // zero-based rank of the median in a window of side 2*r+1
    function automatic logic [5:0] median_rank(input logic [RAD_W-1:0] r);
        logic [5:0] k;
        unique case (r)
            2'd0: k = 6'd0;
            2'd1: k = 6'd4;
            2'd2: k = 6'd12;
            2'd3: k = 6'd24;
            default: k = 6'd0;
        endcase
        return k;
    endfunction

endpackage

### hw/rtl/wmf_in_if.sv
// ----------------------------------------------------------------------------
// wmf_in_if
// input channel: opcode and source pixel with valid/ready
// ----------------------------------------------------------------------------
interface wmf_in_if;
    logic                     valid;
    logic                     ready;
    logic                     op;
    logic [wmf_pkg::PIX_W-1:0] pixel_in;

    modport source (output valid, output op, output pixel_in, input ready);
    modport sink   (input valid, input op, input pixel_in, output ready);
endinterface

### hw/rtl/wmf_out_if.sv
// ----------------------------------------------------------------------------
// wmf_out_if
// output channel: filtered pixel and frame end flag with valid/ready
// ----------------------------------------------------------------------------
interface wmf_out_if;
    logic                     valid;
    logic                     ready;
    logic [wmf_pkg::PIX_W-1:0] pixel_out;
    logic                     frame_end;

    modport source (output valid, output pixel_out, output frame_end, input ready);
    modport sink   (input valid, input pixel_out, input frame_end, output ready);
endinterface

### hw/rtl/wmf_ctrl.sv
// ----------------------------------------------------------------------------
// wmf_ctrl
// sequencer for one word: position, decide, window fetch, bit select, output
// ----------------------------------------------------------------------------
module wmf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  wmf_pkg::t_status i_st,
    output wmf_pkg::t_cmd    o_cmd
);

    wmf_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wmf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            wmf_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = wmf_pkg::ST_POS;
                end
            end
            wmf_pkg::ST_POS: begin
                o_cmd.pos = 1'b1;
                n_state   = wmf_pkg::ST_DEC;
            end
            wmf_pkg::ST_DEC: begin
                o_cmd.dec = 1'b1;
                n_state   = i_st.emit ? wmf_pkg::ST_READ : wmf_pkg::ST_IDLE;
            end
            wmf_pkg::ST_READ: begin
                o_cmd.rd_issue = 1'b1;
                if (i_st.rd_last) begin
                    n_state = wmf_pkg::ST_WAIT;
                end
            end
            wmf_pkg::ST_WAIT: begin
                n_state = wmf_pkg::ST_SEL;
            end
            wmf_pkg::ST_SEL: begin
                o_cmd.sel_step = 1'b1;
                if (i_st.sel_last) begin
                    n_state = wmf_pkg::ST_DONE;
                end
            end
            wmf_pkg::ST_DONE: begin
                if (i_st.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = wmf_pkg::ST_IDLE;
                end
            end
            default: n_state = wmf_pkg::ST_IDLE;
        endcase
    end

endmodule

### hw/rtl/wmf_datapath.sv
// ----------------------------------------------------------------------------
// wmf_datapath
// line store, position counters, window registers and radix median select
// ----------------------------------------------------------------------------
module wmf_datapath #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_RADIUS = 3
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  wmf_pkg::t_cmd               i_cmd,
    output wmf_pkg::t_status            o_st,
    input  logic                        i_op,
    input  logic [wmf_pkg::PIX_W-1:0]   i_pixel_in,
    input  logic                        i_cfg_we,
    input  logic [wmf_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [wmf_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [wmf_pkg::PIX_W-1:0]   o_pixel_out,
    output logic                        o_frame_end
);

    localparam int LINES = 2 * MAX_RADIUS + 1;
    localparam int N_WIN = LINES * LINES;
    localparam int DEPTH = LINES * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int LW    = $clog2(LINES);
    localparam int IW    = $clog2(N_WIN);
    localparam int PW    = RW + WW + 1;
    localparam int XW    = (WW > wmf_pkg::CFG_W) ? WW : wmf_pkg::CFG_W;
    localparam int YW    = (HW > wmf_pkg::CFG_W) ? HW : wmf_pkg::CFG_W;
    localparam int PIX_W = wmf_pkg::PIX_W;
    localparam int RAD_W = wmf_pkg::RAD_W;

    // configuration
    logic [wmf_pkg::CFG_W-1:0] r_cfg_w, r_cfg_h;
    logic [RAD_W-1:0]          r_cfg_r;

    // position state
    logic [CW-1:0] r_in_col, r_out_col;
    logic [RW-1:0] r_in_row, r_out_row;
    logic [LW-1:0] r_in_line, r_out_line;
    logic          r_frame_done;

    // captured word and position products
    logic             r_op;
    logic [PIX_W-1:0] r_pix;
    logic [PW-1:0]    r_pos, r_lag;

    // window fetch
    logic [PIX_W-1:0] r_mem [DEPTH];
    logic [PIX_W-1:0] r_rdata;
    logic             r_ld_pend;
    logic [IW-1:0]    r_ld_idx, r_idx;
    logic [LW-1:0]    r_rd_line, r_wi, r_wj;
    logic [CW-1:0]    r_col, r_col_base;
    logic [RAD_W-1:0] r_we;
    logic [PIX_W-1:0] r_win [N_WIN];

    // radix select
    logic [N_WIN-1:0] r_cand;
    logic [IW-1:0]    r_k;
    logic [2:0]       r_bit;
    logic [PIX_W-1:0] r_res;

    // output register
    logic             r_ov;
    logic [PIX_W-1:0] r_opix;
    logic             r_oend;

    logic [WW-1:0]    eff_w;
    logic [HW-1:0]    eff_h;
    logic [RAD_W-1:0] eff_r;
    logic [XW-1:0]    cfg_wx;
    logic [YW-1:0]    cfg_hx;
    logic             col_wrap, row_wrap, out_col_wrap, out_row_end;
    logic             interior, wr_pix;
    logic [LW:0]      line_sum;
    logic [LW-1:0]    line_start;
    logic [LW-1:0]    side_m1;
    logic [AW-1:0]    wr_addr, rd_addr;
    logic [N_WIN-1:0] plane, zeros;
    logic [IW:0]      zcnt;

    // clamped register values
    always_comb begin
        cfg_wx = XW'(r_cfg_w);
        cfg_hx = YW'(r_cfg_h);
        if (cfg_wx == '0) begin
            eff_w = WW'(1);
        end else if (cfg_wx > XW'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(cfg_wx);
        end
        if (cfg_hx == '0) begin
            eff_h = HW'(1);
        end else if (cfg_hx > YW'(MAX_HEIGHT)) begin
            eff_h = HW'(MAX_HEIGHT);
        end else begin
            eff_h = HW'(cfg_hx);
        end
        eff_r = (r_cfg_r > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : r_cfg_r;
    end

    always_comb begin
        col_wrap     = (WW'(r_in_col) + WW'(1)) >= eff_w;
        row_wrap     = (HW'(r_in_row) + HW'(1)) >= eff_h;
        out_col_wrap = (WW'(r_out_col) + WW'(1)) >= eff_w;
        out_row_end  = (HW'(r_out_row) + HW'(1)) >= eff_h;
        interior     = (RW'(eff_r) < r_out_row)
                    && ((HW + 1)'(r_out_row) + (HW + 1)'(eff_r) < (HW + 1)'(eff_h))
                    && (CW'(eff_r) < r_out_col)
                    && ((WW + 1)'(r_out_col) + (WW + 1)'(eff_r) < (WW + 1)'(eff_w));
        wr_pix       = (r_op == wmf_pkg::OP_PIXEL) && !r_frame_done;
        line_sum     = (LW + 1)'(r_out_line) + (LW + 1)'(LINES) - (LW + 1)'(eff_r);
        line_start   = (line_sum >= (LW + 1)'(LINES)) ? LW'(line_sum - (LW + 1)'(LINES))
                                                      : LW'(line_sum);
        side_m1      = LW'({r_we, 1'b0});
        wr_addr      = AW'(r_in_line) * AW'(MAX_WIDTH) + AW'(r_in_col);
        rd_addr      = AW'(r_rd_line) * AW'(MAX_WIDTH) + AW'(r_col);
    end

    // bit plane and zero count of the surviving candidates
    always_comb begin
        for (int e = 0; e < N_WIN; e++) begin
            plane[e] = r_win[e][r_bit];
        end
        zeros = r_cand & ~plane;
        zcnt  = '0;
        for (int e = 0; e < N_WIN; e++) begin
            zcnt = zcnt + (IW + 1)'(zeros[e]);
        end
    end

    always_comb begin
        o_st.emit       = (r_op == wmf_pkg::OP_PIXEL) ? (!r_frame_done && (r_pos >= r_lag))
                                                      : r_frame_done;
        o_st.rd_last    = (r_wi == side_m1) && (r_wj == side_m1);
        o_st.sel_last   = (r_bit == 3'd0);
        o_st.out_free   = !r_ov || i_out_ready;
        o_st.last       = out_col_wrap && out_row_end;
        o_st.frame_done = r_frame_done;
    end

    // line store
    always_ff @(posedge i_clk) begin
        if (i_cmd.dec && wr_pix) begin
            r_mem[wr_addr] <= r_pix;
        end
        if (i_cmd.rd_issue) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w      <= wmf_pkg::RST_WIDTH;
            r_cfg_h      <= wmf_pkg::RST_HEIGHT;
            r_cfg_r      <= wmf_pkg::RST_RADIUS;
            r_in_col     <= '0;
            r_in_row     <= '0;
            r_in_line    <= '0;
            r_out_col    <= '0;
            r_out_row    <= '0;
            r_out_line   <= '0;
            r_frame_done <= 1'b0;
            r_ld_pend    <= 1'b0;
            r_ov         <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    wmf_pkg::CFG_IMAGE_WIDTH:  r_cfg_w <= i_cfg_data;
                    wmf_pkg::CFG_IMAGE_HEIGHT: r_cfg_h <= i_cfg_data;
                    wmf_pkg::CFG_RADIUS:       r_cfg_r <= i_cfg_data[RAD_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.dec && wr_pix) begin
                if (col_wrap) begin
                    r_in_col <= '0;
                    if (row_wrap) begin
                        r_in_row     <= '0;
                        r_in_line    <= '0;
                        r_frame_done <= 1'b1;
                    end else begin
                        r_in_row  <= r_in_row + RW'(1);
                        r_in_line <= (r_in_line == LW'(LINES - 1)) ? '0 : r_in_line + LW'(1);
                    end
                end else begin
                    r_in_col <= r_in_col + CW'(1);
                end
            end
            r_ld_pend <= i_cmd.rd_issue;
            if (i_cmd.out_load) begin
                r_ov <= 1'b1;
                if (o_st.last) begin
                    r_out_col    <= '0;
                    r_out_row    <= '0;
                    r_out_line   <= '0;
                    r_frame_done <= 1'b0;
                end else if (out_col_wrap) begin
                    r_out_col  <= '0;
                    r_out_row  <= r_out_row + RW'(1);
                    r_out_line <= (r_out_line == LW'(LINES - 1)) ? '0 : r_out_line + LW'(1);
                end else begin
                    r_out_col <= r_out_col + CW'(1);
                end
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_op  <= i_op;
            r_pix <= i_pixel_in;
        end
        if (i_cmd.pos) begin
            r_pos <= PW'(r_in_row) * PW'(eff_w) + PW'(r_in_col);
            r_lag <= PW'(eff_r) * PW'(eff_w) + PW'(eff_r);
        end
        if (i_cmd.dec) begin
            r_we       <= interior ? eff_r : '0;
            r_rd_line  <= interior ? line_start : r_out_line;
            r_col      <= interior ? (r_out_col - CW'(eff_r)) : r_out_col;
            r_col_base <= interior ? (r_out_col - CW'(eff_r)) : r_out_col;
            r_wi       <= '0;
            r_wj       <= '0;
            r_idx      <= '0;
            r_k        <= IW'(wmf_pkg::median_rank(interior ? eff_r : '0));
            r_bit      <= 3'd7;
            r_res      <= '0;
            r_cand     <= '0;
        end
        if (i_cmd.rd_issue) begin
            r_ld_idx <= r_idx;
            r_idx    <= r_idx + IW'(1);
            if (r_wj == side_m1) begin
                r_wj      <= '0;
                r_col     <= r_col_base;
                r_wi      <= r_wi + LW'(1);
                r_rd_line <= (r_rd_line == LW'(LINES - 1)) ? '0 : r_rd_line + LW'(1);
            end else begin
                r_wj  <= r_wj + LW'(1);
                r_col <= r_col + CW'(1);
            end
        end
        if (r_ld_pend) begin
            r_win[r_ld_idx]  <= r_rdata;
            r_cand[r_ld_idx] <= 1'b1;
        end
        if (i_cmd.sel_step) begin
            r_bit <= r_bit - 3'd1;
            if ((IW + 1)'(r_k) < zcnt) begin
                r_cand <= zeros;
            end else begin
                r_k          <= r_k - IW'(zcnt);
                r_cand       <= r_cand & plane;
                r_res[r_bit] <= 1'b1;
            end
        end
        if (i_cmd.out_load) begin
            r_opix <= r_res;
            r_oend <= o_st.last;
        end
    end

    assign o_out_valid = r_ov;
    assign o_pixel_out = r_opix;
    assign o_frame_end = r_oend;

endmodule

### hw/rtl/window_median_filter.sv
// one word at a time, output register stays apart; a pixel word that makes no
// output passes only the position and decide states; one that makes an output
// also reads its n-pixel window through the single read port of the line store
// (n = 9, 25, 49, or 1 at a border pixel), then selects one median bit per cycle
// reset: synchronous active low, registers back to 640 x 480 radius 3, counters 0
// ----------------------------------------------------------------------------
// window_median_filter
// streaming square-window median filter over 8-bit raster pixels
// ----------------------------------------------------------------------------
`include "window_median_filter_defines.svh"

module window_median_filter #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_RADIUS = 3
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    wmf_in_if.sink                        i_in,
    wmf_out_if.source                     o_out,
    input  logic                          i_cfg_we,
    input  logic [wmf_pkg::IDX_W-1:0]     i_cfg_idx,
    input  logic [wmf_pkg::CFG_W-1:0]     i_cfg_data
);

    // command and status between sequencer and datapath
    wmf_pkg::t_cmd    cmd;
    wmf_pkg::t_status st;

    // sequencer: one input word in flight, ready only when idle
    wmf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_st    (st),
        .o_cmd   (cmd)
    );

    // datapath: line store, counters, window and median select
    wmf_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_st        (st),
        .i_op        (i_in.op),
        .i_pixel_in  (i_in.pixel_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_pixel_out (o_out.pixel_out),
        .o_frame_end (o_out.frame_end)
    );

    // a taken word keeps the block busy on the next cycle
    `WMF_ASSERT_NXT(a_busy_after_take, i_clk, i_rst_n, cmd.take, !i_in.ready, "ready after take")
    // a result is loaded only into a free output register
    `WMF_ASSERT_IMP(a_load_free, i_clk, i_rst_n, cmd.out_load, !o_out.valid || o_out.ready, "output overwrite")
    // the flagged word ends the drain phase
    `WMF_ASSERT_NXT(a_last_clears, i_clk, i_rst_n, cmd.out_load && st.last, !st.frame_done && o_out.frame_end, "frame end not closed")

endmodule
